FILE: rtl/core/assert_macros.svh
// Assertion macros used by the top level of the suffix array builder.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/salcp_pkg.sv
// Shared types and constants of the suffix array and LCP builder.
// No dependencies; imported by the interfaces and by all modules but salcp_ram.
package salcp_pkg;

  localparam int ALPHA_MAX = 256;
  localparam int ALPHA_W   = 9;
  localparam int SYM_W     = 8;
  localparam int RANK_QW   = 10;
  localparam int OUT_W     = 10;
  localparam int STAT_W    = 2;
  localparam int APB_AW    = 2;
  localparam int APB_DW    = 32;

  localparam logic [APB_AW-1:0]  ADDR_ALPHA  = '0;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd10;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_BUILT = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  // Sequencer states, one-hot.
  typedef enum logic [31:0] {
    S_IDLE    = 32'd1 << 0,
    S_Q_RD    = 32'd1 << 1,
    S_Q_OUT   = 32'd1 << 2,
    S_INIT_RD = 32'd1 << 3,
    S_INIT_WR = 32'd1 << 4,
    S_CLR     = 32'd1 << 5,
    S_HIST_A  = 32'd1 << 6,
    S_HIST_B  = 32'd1 << 7,
    S_HIST_C  = 32'd1 << 8,
    S_PSUM_RD = 32'd1 << 9,
    S_PSUM_WR = 32'd1 << 10,
    S_PLACE_A = 32'd1 << 11,
    S_PLACE_B = 32'd1 << 12,
    S_PLACE_C = 32'd1 << 13,
    S_PLACE_D = 32'd1 << 14,
    S_SK1     = 32'd1 << 15,
    S_SK2_RD  = 32'd1 << 16,
    S_SK2_WR  = 32'd1 << 17,
    S_COPY_RD = 32'd1 << 18,
    S_COPY_WR = 32'd1 << 19,
    S_RANK_A  = 32'd1 << 20,
    S_RANK_B  = 32'd1 << 21,
    S_RANK_C  = 32'd1 << 22,
    S_RANK_D  = 32'd1 << 23,
    S_FIN_RD  = 32'd1 << 24,
    S_FIN_WR  = 32'd1 << 25,
    S_KAS_A   = 32'd1 << 26,
    S_KAS_B   = 32'd1 << 27,
    S_KAS_C   = 32'd1 << 28,
    S_KAS_D   = 32'd1 << 29,
    S_KAS_E   = 32'd1 << 30,
    S_KAS_F   = 32'd1 << 31
  } state_t;

  // Status of the sequencer as seen by the top level.
  typedef struct packed {
    logic busy;
    logic built;
    logic q_out;
  } salcp_stat_t;

endpackage

FILE: rtl/core/salcp_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on salcp_pkg for field widths.
interface salcp_req_if import salcp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [SYM_W-1:0]   symbol;
  logic               last;
  logic [RANK_QW-1:0] rank_query;

  modport source(output valid, command, symbol, last, rank_query, input ready);
  modport sink(input valid, command, symbol, last, rank_query, output ready);
endinterface

interface salcp_rsp_if import salcp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OUT_W-1:0]  suffix_start;
  logic [OUT_W-1:0]  lcp_length;
  logic [STAT_W-1:0] status;

  modport source(output valid, suffix_start, lcp_length, status, input ready);
  modport sink(input valid, suffix_start, lcp_length, status, output ready);
endinterface

FILE: rtl/core/salcp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module salcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first port: a read of the address being written returns the old word; read data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/salcp_cfg.sv
// APB register block holding the alphabet size.
// Depends on salcp_pkg; provides the clamped alphabet size to the sequencer.
module salcp_cfg import salcp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  output logic [ALPHA_W-1:0] alpha_eff
);

  logic [ALPHA_W-1:0] alphabet_size;

  // Register write on the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_size <= ALPHA_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_ALPHA) begin
      alphabet_size <= pwdata[ALPHA_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ALPHA) ? APB_DW'(alphabet_size) : '0;

  // Zero acts as one, anything above the maximum acts as the maximum.
  always_comb begin
    priority if (alphabet_size == '0) begin
      alpha_eff = ALPHA_W'(1);
    end else if (alphabet_size > ALPHA_W'(ALPHA_MAX)) begin
      alpha_eff = ALPHA_W'(ALPHA_MAX);
    end else begin
      alpha_eff = alphabet_size;
    end
  end

endmodule

FILE: rtl/core/salcp_ctrl.sv
// Build and query sequencer with the text, order, rank, key, count and LCP memories.
// Depends on salcp_pkg, the channel interfaces and salcp_ram.
module salcp_ctrl import salcp_pkg::*; #(
  parameter int MAX_LEN = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [ALPHA_W-1:0] alpha_eff,
  salcp_req_if.sink          request,
  salcp_rsp_if.source        response,
  output salcp_stat_t        stat
);

  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int CNT_DEPTH = (MAX_LEN > ALPHA_MAX) ? MAX_LEN : ALPHA_MAX;
  localparam int CI_W      = $clog2(CNT_DEPTH);
  localparam int CW        = $clog2(CNT_DEPTH + 1);
  localparam int K_W       = LEN_W + 1;
  localparam int QW        = (LEN_W > RANK_QW) ? LEN_W : RANK_QW;

  state_t state, state_next;

  logic [LEN_W-1:0] len, len0;
  logic             built;
  logic [CW-1:0]    m, j;
  logic [K_W-1:0]   k;
  logic [LEN_W-1:0] i, p, acc, h;
  logic [CI_W-1:0]  key, ska, skak, skb;
  logic [IDX_W-1:0] s, r, jp, bpos;
  logic [SYM_W-1:0] ti;
  logic             in_round, ain, bin;
  status_t          qstat;
  logic             qzero;
  logic [OUT_W-1:0] pend_sa, pend_lcp;
  logic             rsp_valid;
  logic [OUT_W-1:0] rsp_start, rsp_lcp;
  status_t          rsp_status;

  // Memory ports.
  logic             t_we, sa_we, rk_we, sk_we, cnt_we, lcp_we;
  logic [IDX_W-1:0] t_waddr, t_raddr, sa_waddr, sa_raddr, rk_waddr, rk_raddr;
  logic [IDX_W-1:0] sk_waddr, sk_raddr, lcp_waddr, lcp_raddr;
  logic [CI_W-1:0]  cnt_waddr, cnt_raddr;
  logic [SYM_W-1:0] t_wdata, t_q;
  logic [IDX_W-1:0] sa_wdata, sa_q, lcp_wdata, lcp_q;
  logic [CI_W-1:0]  rk_wdata, rk_q, sk_wdata, sk_q;
  logic [LEN_W-1:0] cnt_wdata, cnt_q;

  // Derived values.
  logic             req_acc, out_free, i_last, j_last, sk1_last, sa_ge_k, same, kas_ok;
  logic [QW-1:0]    rq_ext;
  logic [SYM_W-1:0] alpha_m1, sym_sat, t_sat;
  logic [LEN_W-1:0] i_inc, psum, cnt_dec, p_new, h_dec;
  logic [K_W-1:0]   sk1_val, sa_minus_k, bpos_k, k_dbl;
  logic [CI_W-1:0]  rank_val, rk_m1;
  logic [LEN_W:0]   ih, jh;

  assign req_acc    = request.valid && request.ready;
  assign out_free   = !rsp_valid || response.ready;
  assign rq_ext     = QW'(request.rank_query);
  assign len0       = built ? '0 : len;
  assign alpha_m1   = SYM_W'(alpha_eff - ALPHA_W'(1));
  assign sym_sat    = (request.symbol > alpha_m1) ? alpha_m1 : request.symbol;
  assign t_sat      = (CW'(t_q) >= m) ? SYM_W'(m - CW'(1)) : t_q;
  assign i_inc      = i + LEN_W'(1);
  assign i_last     = (i_inc == len);
  assign j_last     = ((j + CW'(1)) == m);
  assign psum       = acc + cnt_q;
  assign cnt_dec    = cnt_q - LEN_W'(1);
  assign sk1_val    = K_W'(len) - k + K_W'(p);
  assign sk1_last   = ((K_W'(p) + K_W'(1)) == k);
  assign sa_ge_k    = (K_W'(sa_q) >= k);
  assign sa_minus_k = K_W'(sa_q) - k;
  assign bpos_k     = K_W'(bpos) + k;
  assign k_dbl      = k << 1;
  assign rk_m1      = rk_q - CI_W'(1);
  assign ih         = (LEN_W + 1)'(i) + (LEN_W + 1)'(h);
  assign jh         = (LEN_W + 1)'(jp) + (LEN_W + 1)'(h);
  assign kas_ok     = (ih < (LEN_W + 1)'(len)) && (jh < (LEN_W + 1)'(len));
  assign h_dec      = (h != '0) ? h - LEN_W'(1) : '0;

  // Two adjacent suffixes share a rank when both key halves agree.
  assign same = (ska == skb) && (ain == bin) && (!ain || (skak == sk_q));

  always_comb begin
    priority if (i == '0) begin
      p_new    = LEN_W'(1);
      rank_val = '0;
    end else if (same) begin
      p_new    = p;
      rank_val = CI_W'(p - LEN_W'(1));
    end else begin
      p_new    = p + LEN_W'(1);
      rank_val = CI_W'(p);
    end
  end

  // Memory control and next state.
  always_comb begin
    state_next = state;
    t_we = 1'b0;   t_waddr = '0;   t_wdata = '0;   t_raddr = '0;
    sa_we = 1'b0;  sa_waddr = '0;  sa_wdata = '0;  sa_raddr = '0;
    rk_we = 1'b0;  rk_waddr = '0;  rk_wdata = '0;  rk_raddr = '0;
    sk_we = 1'b0;  sk_waddr = '0;  sk_wdata = '0;  sk_raddr = '0;
    cnt_we = 1'b0; cnt_waddr = '0; cnt_wdata = '0; cnt_raddr = '0;
    lcp_we = 1'b0; lcp_waddr = '0; lcp_wdata = '0; lcp_raddr = '0;
    unique case (state)
      S_IDLE: begin
        if (req_acc) begin
          if (request.command == CMD_LOAD) begin
            if (len0 < LEN_W'(MAX_LEN)) begin
              t_we    = 1'b1;
              t_waddr = len0[IDX_W-1:0];
              t_wdata = sym_sat;
            end
            if (request.last) begin
              state_next = S_INIT_RD;
            end
          end else begin
            sa_raddr   = rq_ext[IDX_W-1:0];
            lcp_raddr  = rq_ext[IDX_W-1:0];
            state_next = S_Q_RD;
          end
        end
      end
      S_Q_RD: state_next = S_Q_OUT;
      S_Q_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      // Saturate the text again and seed ranks and the identity order.
      S_INIT_RD: begin
        t_raddr    = i[IDX_W-1:0];
        state_next = S_INIT_WR;
      end
      S_INIT_WR: begin
        t_we     = 1'b1; t_waddr  = i[IDX_W-1:0]; t_wdata  = t_sat;
        rk_we    = 1'b1; rk_waddr = i[IDX_W-1:0]; rk_wdata = CI_W'(t_sat);
        sk_we    = 1'b1; sk_waddr = i[IDX_W-1:0]; sk_wdata = CI_W'(i);
        state_next = i_last ? S_CLR : S_INIT_RD;
      end
      // Counting sort: clear, histogram, prefix sum, stable placement.
      S_CLR: begin
        cnt_we     = 1'b1;
        cnt_waddr  = j[CI_W-1:0];
        state_next = j_last ? S_HIST_A : S_CLR;
      end
      S_HIST_A: begin
        rk_raddr   = i[IDX_W-1:0];
        state_next = S_HIST_B;
      end
      S_HIST_B: begin
        cnt_raddr  = rk_q;
        state_next = S_HIST_C;
      end
      S_HIST_C: begin
        cnt_we     = 1'b1;
        cnt_waddr  = key;
        cnt_wdata  = cnt_q + LEN_W'(1);
        state_next = i_last ? S_PSUM_RD : S_HIST_A;
      end
      S_PSUM_RD: begin
        cnt_raddr  = j[CI_W-1:0];
        state_next = S_PSUM_WR;
      end
      S_PSUM_WR: begin
        cnt_we     = 1'b1;
        cnt_waddr  = j[CI_W-1:0];
        cnt_wdata  = psum;
        state_next = j_last ? S_PLACE_A : S_PSUM_RD;
      end
      S_PLACE_A: begin
        sk_raddr   = i[IDX_W-1:0];
        state_next = S_PLACE_B;
      end
      S_PLACE_B: begin
        rk_raddr   = sk_q[IDX_W-1:0];
        state_next = S_PLACE_C;
      end
      S_PLACE_C: begin
        cnt_raddr  = rk_q;
        state_next = S_PLACE_D;
      end
      S_PLACE_D: begin
        cnt_we    = 1'b1;
        cnt_waddr = key;
        cnt_wdata = cnt_dec;
        sa_we     = 1'b1;
        sa_waddr  = cnt_dec[IDX_W-1:0];
        sa_wdata  = s;
        priority if (i != '0) begin
          state_next = S_PLACE_A;
        end else if (in_round) begin
          state_next = S_COPY_RD;
        end else if (len > LEN_W'(1)) begin
          state_next = S_SK1;
        end else begin
          state_next = S_FIN_RD;
        end
      end
      // Order by second key: the tail suffixes first, then shifted order.
      S_SK1: begin
        sk_we      = 1'b1;
        sk_waddr   = p[IDX_W-1:0];
        sk_wdata   = CI_W'(sk1_val);
        state_next = sk1_last ? S_SK2_RD : S_SK1;
      end
      S_SK2_RD: begin
        sa_raddr   = i[IDX_W-1:0];
        state_next = S_SK2_WR;
      end
      S_SK2_WR: begin
        if (sa_ge_k) begin
          sk_we    = 1'b1;
          sk_waddr = p[IDX_W-1:0];
          sk_wdata = CI_W'(sa_minus_k);
        end
        state_next = i_last ? S_CLR : S_SK2_RD;
      end
      // Keep the old ranks as comparison keys.
      S_COPY_RD: begin
        rk_raddr   = i[IDX_W-1:0];
        state_next = S_COPY_WR;
      end
      S_COPY_WR: begin
        sk_we      = 1'b1;
        sk_waddr   = i[IDX_W-1:0];
        sk_wdata   = rk_q;
        state_next = i_last ? S_RANK_A : S_COPY_RD;
      end
      // Rerank along the new order.
      S_RANK_A: begin
        sa_raddr   = i[IDX_W-1:0];
        state_next = S_RANK_B;
      end
      S_RANK_B: begin
        sk_raddr   = sa_q;
        state_next = S_RANK_C;
      end
      S_RANK_C: begin
        sk_raddr   = bpos_k[IDX_W-1:0];
        state_next = S_RANK_D;
      end
      S_RANK_D: begin
        rk_we    = 1'b1;
        rk_waddr = bpos;
        rk_wdata = rank_val;
        priority if (!i_last) begin
          state_next = S_RANK_A;
        end else if (p_new >= len) begin
          state_next = S_FIN_RD;
        end else if (k_dbl < K_W'(len)) begin
          state_next = S_SK1;
        end else begin
          state_next = S_FIN_RD;
        end
      end
      // Final ranks are the inverse of the order.
      S_FIN_RD: begin
        sa_raddr   = i[IDX_W-1:0];
        state_next = S_FIN_WR;
      end
      S_FIN_WR: begin
        rk_we      = 1'b1;
        rk_waddr   = sa_q;
        rk_wdata   = CI_W'(i);
        state_next = i_last ? S_KAS_A : S_FIN_RD;
      end
      // Height array: each text symbol pair is read in KAS_D and KAS_E and compared in KAS_F.
      S_KAS_A: begin
        rk_raddr   = i[IDX_W-1:0];
        state_next = S_KAS_B;
      end
      S_KAS_B: begin
        if (rk_q == '0) begin
          lcp_we     = 1'b1;
          lcp_waddr  = '0;
          state_next = i_last ? S_IDLE : S_KAS_A;
        end else begin
          sa_raddr   = rk_m1[IDX_W-1:0];
          state_next = S_KAS_C;
        end
      end
      S_KAS_C: state_next = S_KAS_D;
      S_KAS_D: begin
        if (kas_ok) begin
          t_raddr    = ih[IDX_W-1:0];
          state_next = S_KAS_E;
        end else begin
          lcp_we     = 1'b1;
          lcp_waddr  = r;
          lcp_wdata  = IDX_W'(h);
          state_next = i_last ? S_IDLE : S_KAS_A;
        end
      end
      S_KAS_E: begin
        t_raddr    = jh[IDX_W-1:0];
        state_next = S_KAS_F;
      end
      S_KAS_F: begin
        if (ti == t_q) begin
          state_next = S_KAS_D;
        end else begin
          lcp_we     = 1'b1;
          lcp_waddr  = r;
          lcp_wdata  = IDX_W'(h);
          state_next = i_last ? S_IDLE : S_KAS_A;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      built     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      // Result register: take a new item or release the one accepted.
      if (state == S_Q_OUT && out_free) begin
        rsp_valid  <= 1'b1;
        rsp_start  <= pend_sa;
        rsp_lcp    <= pend_lcp;
        rsp_status <= qstat;
      end else if (response.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            if (request.command == CMD_LOAD) begin
              built <= 1'b0;
              len   <= (len0 < LEN_W'(MAX_LEN)) ? len0 + LEN_W'(1) : len0;
              m     <= CW'(alpha_eff);
              i     <= '0;
            end else begin
              qzero <= (rq_ext == '0);
              priority if (!built) begin
                qstat <= ST_NOT_BUILT;
              end else if (rq_ext >= QW'(len)) begin
                qstat <= ST_RANGE;
              end else begin
                qstat <= ST_OK;
              end
            end
          end
        end
        S_Q_RD: begin
          pend_sa  <= (qstat == ST_OK) ? OUT_W'(sa_q) : '0;
          pend_lcp <= (qstat == ST_OK && !qzero) ? OUT_W'(lcp_q) : '0;
        end
        S_INIT_WR: begin
          i <= i_inc;
          if (i_last) begin
            in_round <= 1'b0;
            j        <= '0;
          end
        end
        S_CLR: begin
          j <= j + CW'(1);
          if (j_last) begin
            i <= '0;
          end
        end
        S_HIST_B: key <= rk_q;
        S_HIST_C: begin
          i <= i_inc;
          if (i_last) begin
            j   <= '0;
            acc <= '0;
          end
        end
        S_PSUM_WR: begin
          acc <= psum;
          j   <= j + CW'(1);
          if (j_last) begin
            i <= len - LEN_W'(1);
          end
        end
        S_PLACE_B: s <= sk_q[IDX_W-1:0];
        S_PLACE_C: key <= rk_q;
        S_PLACE_D: begin
          if (i != '0) begin
            i <= i - LEN_W'(1);
          end else begin
            p <= '0;
            if (!in_round) begin
              k <= K_W'(1);
            end
          end
        end
        S_SK1: begin
          p <= p + LEN_W'(1);
          if (sk1_last) begin
            i <= '0;
          end
        end
        S_SK2_WR: begin
          if (sa_ge_k) begin
            p <= p + LEN_W'(1);
          end
          i <= i_inc;
          if (i_last) begin
            in_round <= 1'b1;
            j        <= '0;
          end
        end
        S_COPY_WR: i <= i_last ? '0 : i_inc;
        S_RANK_B: bpos <= sa_q;
        S_RANK_C: begin
          skb <= sk_q;
          bin <= (bpos_k < K_W'(len));
        end
        S_RANK_D: begin
          ska  <= skb;
          skak <= sk_q;
          ain  <= bin;
          if (!i_last) begin
            p <= p_new;
            i <= i_inc;
          end else begin
            i <= '0;
            if (p_new < len) begin
              m <= CW'(p_new);
              k <= k_dbl;
              p <= '0;
            end else begin
              p <= p_new;
            end
          end
        end
        S_FIN_WR: begin
          i <= i_last ? '0 : i_inc;
          if (i_last) begin
            h <= '0;
          end
        end
        S_KAS_B: begin
          r <= rk_q[IDX_W-1:0];
          if (rk_q == '0) begin
            h <= '0;
            i <= i_inc;
            if (i_last) begin
              built <= 1'b1;
            end
          end
        end
        S_KAS_C: jp <= sa_q;
        S_KAS_D: begin
          if (!kas_ok) begin
            h <= h_dec;
            i <= i_inc;
            if (i_last) begin
              built <= 1'b1;
            end
          end
        end
        S_KAS_E: ti <= t_q;
        S_KAS_F: begin
          if (ti == t_q) begin
            h <= h + LEN_W'(1);
          end else begin
            h <= h_dec;
            i <= i_inc;
            if (i_last) begin
              built <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign request.ready         = (state == S_IDLE);
  assign response.valid        = rsp_valid;
  assign response.suffix_start = rsp_start;
  assign response.lcp_length   = rsp_lcp;
  assign response.status       = rsp_status;

  assign stat.busy  = !(state == S_IDLE || state == S_Q_RD || state == S_Q_OUT);
  assign stat.built = built;
  assign stat.q_out = (state == S_Q_OUT);

  // Memories.
  salcp_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_text (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_q)
  );
  salcp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LEN)) u_order (
    .clk(clk), .we(sa_we), .waddr(sa_waddr), .wdata(sa_wdata), .raddr(sa_raddr), .rdata(sa_q)
  );
  salcp_ram #(.WIDTH(CI_W), .DEPTH(MAX_LEN)) u_rank (
    .clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata), .raddr(rk_raddr), .rdata(rk_q)
  );
  salcp_ram #(.WIDTH(CI_W), .DEPTH(MAX_LEN)) u_key (
    .clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata), .raddr(sk_raddr), .rdata(sk_q)
  );
  salcp_ram #(.WIDTH(LEN_W), .DEPTH(CNT_DEPTH)) u_count (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata), .raddr(cnt_raddr),
    .rdata(cnt_q)
  );
  salcp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LEN)) u_lcp (
    .clk(clk), .we(lcp_we), .waddr(lcp_waddr), .wdata(lcp_wdata), .raddr(lcp_raddr),
    .rdata(lcp_q)
  );

endmodule

FILE: rtl/core/suffix_array_lcp_builder.sv
// Load item: the symbol goes to the text memory when accepted. Query item: the order
// and LCP reads are registered as a pending result, then in the result register when
// it is free. Build: sort by symbol, then per doubling round second keys, a sort, a
// key copy and a rerank, then final ranks and heights. Each memory has one read port.
// Synchronous reset clears length, built flag and output valid; no memory clearing.
// Depends on salcp_pkg, salcp_if, salcp_cfg, salcp_ctrl and assert_macros.svh.
`include "assert_macros.svh"

module suffix_array_lcp_builder import salcp_pkg::*; #(
  parameter int MAX_LEN = 1024
) (
  input  logic              clk,
  input  logic              rst,
  salcp_req_if.sink         request,
  salcp_rsp_if.source       response,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [ALPHA_W-1:0] alpha_eff;
  salcp_stat_t        stat;

  // Configuration register.
  salcp_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .alpha_eff(alpha_eff)
  );

  // Build and query sequencer.
  salcp_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
    .clk(clk), .rst(rst), .alpha_eff(alpha_eff),
    .request(request), .response(response), .stat(stat)
  );

  // A final load item always starts a build.
  `ASSERT_NEXT(a_build_starts, clk, rst, request.valid && request.ready && request.command == CMD_LOAD && request.last, stat.busy)
  // A new result only comes from the result stage of a query.
  `ASSERT_IMPLIES(a_rsp_from_query, clk, rst, $rose(response.valid), $past(stat.q_out))
  // The built flag is only set at the end of a build.
  `ASSERT_IMPLIES(a_built_after_build, clk, rst, $rose(stat.built), $past(stat.busy))

endmodule

FILE: verif/tb.sv
// Self-checking testbench for suffix_array_lcp_builder: string loads, builds, rank queries.
// Depends on salcp_pkg, the salcp_req_if and salcp_rsp_if interfaces, and the block's RTL.
module tb;
  import salcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEXT_MAX = 1024;
  localparam int BUCKET_N = TEXT_MAX + ALPHA_MAX;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    cmd_t         cmd;
    logic [7:0]   sym;
    logic         last;
    logic [9:0]   rank;
  } req_item_t;

  typedef struct {
    logic [9:0] start;
    logic [9:0] lcp;
    status_t    st;
  } answer_t;

  // One row of the directed table: an item and, where known at a glance, its answer.
  typedef struct {
    cmd_t       cmd;
    logic [7:0] sym;
    logic       last;
    logic [9:0] rank;
    bit         typed;
    logic [9:0] start;
    logic [9:0] lcp;
    status_t    st;
  } row_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  salcp_req_if req_if ();
  salcp_rsp_if rsp_if ();

  suffix_array_lcp_builder u_dut (
    .clk(clk), .rst(rst), .request(req_if), .response(rsp_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow state of the builder.
  logic [8:0] alpha_reg;
  int txt [TEXT_MAX];
  int sa [TEXT_MAX];
  int rk [TEXT_MAX];
  int sk [TEXT_MAX];
  int cnt [BUCKET_N];
  int lcp_tab [TEXT_MAX];
  int text_len;
  bit is_built;

  answer_t pending_answers[$];
  int err_count;
  int items_sent;
  int answers_seen;
  int builds_done;
  int longest_text;
  bit quiet;
  bit hold_req;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("suffix_array_lcp_builder: mismatch");
    $finish;
  end

  function automatic int eff_alpha();
    if (alpha_reg == 0) return 1;
    if (alpha_reg > ALPHA_MAX) return ALPHA_MAX;
    return alpha_reg;
  endfunction

  // Stable counting sort of the order held in sk, keyed by rk.
  function automatic void sort_by_rank(int n, int m);
    int s;
    for (int i = 0; i < BUCKET_N; i++) cnt[i] = 0;
    for (int i = 0; i < n; i++) cnt[rk[i]]++;
    for (int i = 1; i < m; i++) cnt[i] += cnt[i-1];
    for (int i = n - 1; i >= 0; i--) begin
      s = sk[i];
      cnt[rk[s]]--;
      sa[cnt[rk[s]]] = s;
    end
  endfunction

  // Prefix doubling for the suffix order, then Kasai for the heights.
  function automatic void build_index();
    int n, m, k, p, a, b, h, r, j;
    bit same, ain, bin;
    n = text_len;
    m = eff_alpha();
    for (int i = 0; i < n; i++) begin
      if (txt[i] > m - 1) txt[i] = m - 1;
      rk[i] = txt[i];
      sk[i] = i;
    end
    sort_by_rank(n, m);
    for (k = 1; k < n; k = k << 1) begin
      p = 0;
      for (int i = n - k; i < n; i++) begin
        sk[p] = i;
        p++;
      end
      for (int i = 0; i < n; i++) begin
        if (sa[i] >= k) begin
          sk[p] = sa[i] - k;
          p++;
        end
      end
      sort_by_rank(n, m);
      for (int i = 0; i < n; i++) sk[i] = rk[i];
      rk[sa[0]] = 0;
      p = 1;
      for (int i = 1; i < n; i++) begin
        a = sa[i-1];
        b = sa[i];
        same = (sk[a] == sk[b]);
        if (same) begin
          ain = (a + k < n);
          bin = (b + k < n);
          if (ain != bin) same = 0;
          else if (ain && sk[a+k] != sk[b+k]) same = 0;
        end
        if (same) rk[b] = p - 1;
        else begin
          rk[b] = p;
          p++;
        end
      end
      if (p >= n) break;
      m = p;
    end
    for (int i = 0; i < n; i++) rk[sa[i]] = i;
    h = 0;
    for (int i = 0; i < n; i++) begin
      r = rk[i];
      if (r == 0) begin
        lcp_tab[0] = 0;
        h = 0;
        continue;
      end
      j = sa[r-1];
      while (i + h < n && j + h < n && txt[i+h] == txt[j+h]) h++;
      lcp_tab[r] = h;
      if (h > 0) h--;
    end
    is_built = 1;
    builds_done++;
    if (n > longest_text) longest_text = n;
  endfunction

  // Advance the shadow state by one accepted item; returns 1 when a result is due.
  function automatic bit apply_item(req_item_t it, output answer_t ans);
    int s;
    ans = '{start: '0, lcp: '0, st: ST_OK};
    if (it.cmd == CMD_LOAD) begin
      s = it.sym;
      if (is_built) begin
        is_built = 0;
        text_len = 0;
      end
      if (s > eff_alpha() - 1) s = eff_alpha() - 1;
      if (text_len < TEXT_MAX) begin
        txt[text_len] = s;
        text_len++;
      end
      if (it.last) build_index();
      return 0;
    end
    if (!is_built) ans.st = ST_NOT_BUILT;
    else if (it.rank >= text_len) ans.st = ST_RANGE;
    else begin
      ans.start = 10'(sa[it.rank]);
      ans.lcp = (it.rank == 0) ? 10'd0 : 10'(lcp_tab[it.rank]);
    end
    return 1;
  endfunction

  task automatic note_mismatch(string what, int got, int want);
    $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // Offer one item, optionally after a short gap, and wait for its acceptance.
  task automatic send_item(req_item_t it, bit typed = 0, answer_t typed_ans = '{0, 0, ST_OK});
    answer_t ans;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.command <= it.cmd;
    req_if.symbol <= it.sym;
    req_if.last <= it.last;
    req_if.rank_query <= it.rank;
    do @(posedge clk); while (!req_if.ready);
    items_sent++;
    if (apply_item(it, ans)) pending_answers.push_back(typed ? typed_ans : ans);
  endtask

  task automatic send_load(int sym, bit last);
    req_item_t it;
    it = '{cmd: CMD_LOAD, sym: sym[7:0], last: last, rank: 10'($urandom)};
    send_item(it);
  endtask

  task automatic send_query(int rank);
    req_item_t it;
    it = '{cmd: CMD_QUERY, sym: 8'($urandom), last: 1'($urandom), rank: rank[9:0]};
    send_item(it);
  endtask

  // Stop offering and wait until every due result has arrived, then let the block settle.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_alpha(int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_ALPHA;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    alpha_reg = value[8:0];
    @(posedge clk);
  endtask

  function automatic int pick_rank();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7 && text_len > 0) return $urandom_range(0, text_len - 1);
    if (r == 7) return text_len;
    return $urandom_range(0, 1023);
  endfunction

  // Load one random string, build it, then query it.
  task automatic run_string(int n);
    int style, period, s;
    int pat[4];
    style = $urandom_range(0, 3);
    period = $urandom_range(1, 4);
    for (int i = 0; i < 4; i++) pat[i] = $urandom_range(0, eff_alpha() - 1);
    for (int i = 0; i < n; i++) begin
      case (style)
        0: s = $urandom_range(0, eff_alpha() - 1);
        1: s = $urandom_range(0, 255);
        2: s = pat[i % period];
        default: s = pat[$urandom_range(0, 1)];
      endcase
      if (style == 2 && $urandom_range(0, 9) == 0) s = $urandom_range(0, 255);
      // Occasional stray query while the string is only partly loaded.
      if ($urandom_range(0, 19) == 0) send_query($urandom_range(0, 1023));
      send_load(s, i == n - 1);
    end
    repeat ($urandom_range(1, n + 3)) send_query(pick_rank());
  endtask

  // Check each accepted result and drive ready with random stalls and one long hold.
  initial begin
    int stall, hold;
    answer_t want;
    stall = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) begin
        answers_seen++;
        if (pending_answers.size() == 0) begin
          note_mismatch("results due", 0, 1);
        end else begin
          want = pending_answers.pop_front();
          if (rsp_if.status !== want.st) note_mismatch("status", rsp_if.status, want.st);
          if (rsp_if.suffix_start !== want.start)
            note_mismatch("suffix_start", rsp_if.suffix_start, want.start);
          if (rsp_if.lcp_length !== want.lcp)
            note_mismatch("lcp_length", rsp_if.lcp_length, want.lcp);
        end
      end
      if (hold > 0) begin
        hold--;
        rsp_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 0;
        hold = HOLD_CYCLES;
        rsp_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        rsp_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 4);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, directed table, configured random phases, full buffer, quiet tail.
  initial begin
    row_t rows[] = '{
      '{CMD_QUERY, 8'd0,   1'b0, 10'd0,    1'b1, 10'd0, 10'd0, ST_NOT_BUILT},
      '{CMD_LOAD,  8'd255, 1'b1, 10'd0,    1'b0, 10'd0, 10'd0, ST_OK},
      '{CMD_QUERY, 8'd0,   1'b0, 10'd0,    1'b1, 10'd0, 10'd0, ST_OK},
      '{CMD_QUERY, 8'd0,   1'b0, 10'd1,    1'b1, 10'd0, 10'd0, ST_RANGE},
      '{CMD_QUERY, 8'd255, 1'b1, 10'd1023, 1'b1, 10'd0, 10'd0, ST_RANGE},
      '{CMD_LOAD,  8'd1,   1'b0, 10'd1023, 1'b0, 10'd0, 10'd0, ST_OK},
      '{CMD_QUERY, 8'd0,   1'b0, 10'd0,    1'b1, 10'd0, 10'd0, ST_NOT_BUILT},
      '{CMD_LOAD,  8'd0,   1'b0, 10'd0,    1'b0, 10'd0, 10'd0, ST_OK},
      '{CMD_LOAD,  8'd200, 1'b0, 10'd0,    1'b0, 10'd0, 10'd0, ST_OK},
      '{CMD_LOAD,  8'd0,   1'b0, 10'd0,    1'b0, 10'd0, 10'd0, ST_OK},
      '{CMD_LOAD,  8'd9,   1'b0, 10'd0,    1'b0, 10'd0, 10'd0, ST_OK},
      '{CMD_LOAD,  8'd0,   1'b1, 10'd0,    1'b0, 10'd0, 10'd0, ST_OK},
      '{CMD_QUERY, 8'd0,   1'b0, 10'd0,    1'b0, 10'd0, 10'd0, ST_OK},
      '{CMD_QUERY, 8'd0,   1'b0, 10'd1,    1'b0, 10'd0, 10'd0, ST_OK},
      '{CMD_QUERY, 8'd0,   1'b0, 10'd2,    1'b0, 10'd0, 10'd0, ST_OK},
      '{CMD_QUERY, 8'd0,   1'b0, 10'd3,    1'b0, 10'd0, 10'd0, ST_OK},
      '{CMD_QUERY, 8'd0,   1'b0, 10'd4,    1'b0, 10'd0, 10'd0, ST_OK},
      '{CMD_QUERY, 8'd0,   1'b0, 10'd5,    1'b0, 10'd0, 10'd0, ST_OK},
      '{CMD_QUERY, 8'd0,   1'b0, 10'd6,    1'b1, 10'd0, 10'd0, ST_RANGE}
    };
    int alphas[] = '{1, 256, 0, 511, 2, 4, 27, 10, 300, 3};
    req_item_t it;
    int ph;

    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_if.valid <= 1'b0;
    req_if.command <= CMD_LOAD;
    req_if.symbol <= '0;
    req_if.last <= 1'b0;
    req_if.rank_query <= '0;
    rsp_if.ready <= 1'b0;
    alpha_reg = ALPHA_RESET;
    text_len = 0;
    is_built = 0;
    err_count = 0;
    items_sent = 0;
    answers_seen = 0;
    builds_done = 0;
    longest_text = 0;
    quiet = 0;
    hold_req = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      it = '{cmd: rows[i].cmd, sym: rows[i].sym, last: rows[i].last, rank: rows[i].rank};
      send_item(it, rows[i].typed, '{rows[i].start, rows[i].lcp, rows[i].st});
    end
    drain();

    // Random phases, each under its own alphabet setting.
    ph = 0;
    while (ph < alphas.size()) begin
      write_alpha(alphas[ph]);
      if (ph % 3 == 1) quiet = 1;
      if ($urandom_range(0, 7) == 0) run_string($urandom_range(17, 32));
      else run_string($urandom_range(1, 16));
      if (ph == 2) begin
        // Hold results back while queries keep coming, so the block backs up.
        quiet = 1;
        hold_req = 1;
        repeat (10) send_query(pick_rank());
      end
      quiet = 0;
      drain();
      ph++;
    end

    // Overfill the text buffer; the symbols past the end are dropped.
    write_alpha(2);
    for (int i = 0; i < TEXT_MAX + 6; i++)
      send_load((i % 7 == 3 || $urandom_range(0, 15) == 0) ? 1 : 0, i == TEXT_MAX + 5);
    send_query(1023);
    repeat (30) send_query($urandom_range(0, 1023));
    drain();

    // Closing stretch with no idling on either side.
    write_alpha(ALPHA_RESET);
    quiet = 1;
    repeat (2) run_string($urandom_range(8, 20));
    drain();

    $display("Sent %0d items, checked %0d results over %0d builds (longest text %0d).",
             items_sent, answers_seen, builds_done, longest_text);
    $display("Alphabet sizes from 0 to 511 were written, with %0d errors.", err_count);
    if (err_count == 0 && pending_answers.size() == 0) begin
      $display("suffix_array_lcp_builder: match");
    end else begin
      $display("suffix_array_lcp_builder: mismatch");
    end
    $finish;
  end
endmodule
